[rtl/core/vfe_pkg.sv]
// Package for the volume fade envelope: widths, codes, fixed-point constants,
// and the command and status types shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vfe_pkg;

    // Fixed-point format of the volume: 1.0 is 1 << VOLUME_FRACTION_BITS.
    localparam int unsigned VOLUME_FRACTION_BITS = 16;
    localparam int unsigned VOL_W      = VOLUME_FRACTION_BITS + 1;
    localparam int unsigned ELAP_W     = 15;
    localparam int unsigned SHAPE_W    = 2;
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = VOL_W;

    localparam logic [VOL_W-1:0]  FULL_SCALE = VOL_W'(1) << VOLUME_FRACTION_BITS;
    localparam logic [ELAP_W-1:0] TICK_MAX   = '1;

    // Shared multiplier and divider sizes.
    localparam int unsigned PROD_W     = 2 * VOL_W;
    localparam int unsigned STEP_W     = PROD_W - VOLUME_FRACTION_BITS;
    localparam int unsigned DIV_NUM_W  = VOL_W + ELAP_W;
    localparam int unsigned QUO_W      = DIV_NUM_W - ELAP_W;
    localparam int unsigned DIV_CNT_W  = $clog2(QUO_W);

    // Quarter-sine table generation.
    localparam int unsigned SINE_ENTRIES_DEFAULT = 256;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int unsigned ROUND_SHIFT  = 30 - VOLUME_FRACTION_BITS;
    localparam int unsigned TAYLOR_TERMS = 12;
    localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

    // Request types.
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd2;

    // Fade shapes.
    localparam logic [SHAPE_W-1:0] SHAPE_JUMP   = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_LINEAR = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SINE   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP     = 2'd3;

    // Source of the new volume when a fade step is applied.
    localparam logic [1:0] APPLY_LIM  = 2'd0;
    localparam logic [1:0] APPLY_LIN  = 2'd1;
    localparam logic [1:0] APPLY_SINE = 2'd2;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } vfe_cfg_wr_t;

    typedef struct packed {
        logic       accept;
        logic       setup;
        logic       mul;
        logic       mul_shape;
        logic       div_load;
        logic       div_sine;
        logic       div_step;
        logic       rom_rd;
        logic       apply;
        logic [1:0] apply_sel;
        logic       out_load;
    } vfe_cmd_t;

    typedef struct packed {
        logic tick_fading;
        logic mode_jump;
        logic mode_sine;
        logic div_last;
    } vfe_status_t;

endpackage

`default_nettype wire

[rtl/core/volume_fade_envelope.sv]
// A set, start-fade or idle tick goes through setup to the result register; a
// fading tick also takes the jump, linear or quarter-sine path, the last two
// through the 17-step restoring divider that forms the fade fraction. Requests
// go one at a time: the next is taken once the last is loaded for output.
// Reset: aresetn is synchronous and active low; it clears the channel state and
// the registers (fade_shape becomes linear) and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module volume_fade_envelope import vfe_pkg::*; #(
    parameter int unsigned SINE_TABLE_ENTRIES = SINE_ENTRIES_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Request channel.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [REQ_W-1:0]      s_req_type,
    input  wire logic [VOL_W-1:0]      s_new_volume,
    input  wire logic                  s_new_playing,
    // Result channel.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [VOL_W-1:0]           m_volume,
    output logic                       m_fading,
    output logic                       m_playing,
    output logic                       m_stop_request
);

    // The controller walks each request transaction through setup, the shared
    // multiplier, the divider and the sine table as the fade shape needs, and
    // then parks the result in the output register. A new request transaction
    // is taken as soon as the result has been handed to that register, even
    // while the downstream side has not yet taken it.

    vfe_cfg_wr_t cfg_wr;
    vfe_cmd_t    cmd;
    vfe_status_t status;

    assign cfg_wr.wr_en = cfg_wr_en;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.wdata = cfg_wdata;

    vfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The request fields are captured by the datapath in the accepting cycle,
    // so they only need to be held until the handshake completes.
    vfe_datapath #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr           (cfg_wr),
        .cmd              (cmd),
        .status           (status),
        .in_req_type      (s_req_type),
        .in_new_volume    (s_new_volume),
        .in_new_playing   (s_new_playing),
        .out_volume       (m_volume),
        .out_fading       (m_fading),
        .out_playing      (m_playing),
        .out_stop_request (m_stop_request)
    );

endmodule

`default_nettype wire

[rtl/core/vfe_ctrl.sv]
// Controller of the volume fade envelope: sequences the datapath per transaction
// and owns both handshakes. Depends on vfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfe_ctrl import vfe_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire vfe_status_t status,
    output vfe_cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_EVAL  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_DLOAD = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_ROM   = 4'd6;
    localparam logic [3:0] ST_APPLY = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_shape = (mode_reg == APPLY_SINE);
        cmd.div_sine  = (mode_reg == APPLY_SINE);
        cmd.apply_sel = mode_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = status.tick_fading ? ST_EVAL : ST_DONE;
            end
            ST_EVAL: begin
                if (status.mode_jump) begin
                    mode_next  = APPLY_LIM;
                    state_next = ST_APPLY;
                end else if (status.mode_sine) begin
                    mode_next  = APPLY_SINE;
                    state_next = ST_DLOAD;
                end else begin
                    mode_next  = APPLY_LIN;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = (mode_reg == APPLY_SINE) ? ST_APPLY : ST_DLOAD;
            end
            ST_DLOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = (mode_reg == APPLY_SINE) ? ST_ROM : ST_APPLY;
                end
            end
            ST_ROM: begin
                cmd.rom_rd = 1'b1;
                state_next = ST_MUL;
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= APPLY_LIM;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/vfe_datapath.sv]
// Datapath of the volume fade envelope: configuration and channel state, the
// shared multiplier, the restoring divider and the quarter-sine table.
// Depends on vfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfe_datapath import vfe_pkg::*; #(
    parameter int unsigned SINE_TABLE_ENTRIES = SINE_ENTRIES_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire vfe_cfg_wr_t        cfg_wr,
    input  wire vfe_cmd_t           cmd,
    output vfe_status_t             status,
    input  wire logic [REQ_W-1:0]   in_req_type,
    input  wire logic [VOL_W-1:0]   in_new_volume,
    input  wire logic               in_new_playing,
    output logic [VOL_W-1:0]        out_volume,
    output logic                    out_fading,
    output logic                    out_playing,
    output logic                    out_stop_request
);

    localparam int unsigned ROM_DEPTH = SINE_TABLE_ENTRIES + 1;
    localparam int unsigned IDX_W     = $clog2(ROM_DEPTH);

    // Table entry i is sin(i * pi / 2 / entries) in volume format, from a
    // truncated Q30 Taylor series, rounded half up and capped at full scale.
    function automatic logic [VOL_W-1:0] sine_rom_entry(input int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned plus;
        longint unsigned minus;
        longint unsigned s;
        longint unsigned v;
        x     = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
        x2    = (x * x) >> 30;
        term  = x;
        plus  = x;
        minus = 64'd0;
        for (int k = 0; k < TAYLOR_TERMS; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k[0] == 1'b0) begin
                minus = minus + term;
            end else begin
                plus = plus + term;
            end
        end
        s = (plus > minus) ? plus - minus : 64'd0;
        v = (s + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        return (v > 64'(FULL_SCALE)) ? FULL_SCALE : VOL_W'(v);
    endfunction

    logic [VOL_W-1:0] sine_rom [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        localparam logic [VOL_W-1:0] ENTRY = sine_rom_entry(g);
        assign sine_rom[g] = ENTRY;
    end

    // Configuration registers.
    logic [VOL_W-1:0]   limit_reg;
    logic [ELAP_W-1:0]  duration_reg;
    logic [SHAPE_W-1:0] shape_cfg_reg;
    logic               stop_cfg_reg;

    // Channel state.
    logic [VOL_W-1:0]  current_reg;
    logic [VOL_W-1:0]  start_reg;
    logic [ELAP_W-1:0] elapsed_reg;
    logic              fade_reg;
    logic              play_reg;
    logic              stop_req_reg;

    // Captured transaction and working registers.
    logic [REQ_W-1:0]     req_reg;
    logic [VOL_W-1:0]     nvol_reg;
    logic                 nplay_reg;
    logic [VOL_W-1:0]     lim_reg;
    logic                 up_reg;
    logic [VOL_W-1:0]     d_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ELAP_W-1:0]    rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [VOL_W-1:0]     shape_reg;

    logic [VOL_W-1:0]     lim_c;
    logic                 up_c;
    logic [VOL_W-1:0]     mul_b;
    logic [DIV_NUM_W-1:0] div_num;
    logic [ELAP_W:0]      div_trial;
    logic                 div_bit;
    logic [QUO_W-1:0]     idx_full;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     rom_addr;
    logic [STEP_W-1:0]    step_raw;
    logic [VOL_W-1:0]     step_c;
    logic [VOL_W-1:0]     new_vol;

    assign lim_c = (limit_reg > FULL_SCALE) ? FULL_SCALE : limit_reg;
    assign up_c  = (lim_c > start_reg);

    assign status.tick_fading = (req_reg == REQ_TICK) && fade_reg;
    assign status.mode_jump   = (duration_reg == '0) || (elapsed_reg >= duration_reg)
                                || !((shape_cfg_reg == SHAPE_LINEAR)
                                     || (shape_cfg_reg == SHAPE_SINE));
    assign status.mode_sine   = (shape_cfg_reg == SHAPE_SINE);
    assign status.div_last    = (div_cnt_reg == DIV_CNT_W'(QUO_W - 1));

    assign mul_b   = cmd.mul_shape ? shape_reg : VOL_W'(elapsed_reg);
    assign div_num = cmd.div_sine
                   ? DIV_NUM_W'(elapsed_reg) * DIV_NUM_W'(SINE_TABLE_ENTRIES)
                   : prod_reg[DIV_NUM_W-1:0];

    assign div_trial = {rem_reg, quo_reg[QUO_W-1]};
    assign div_bit   = (div_trial >= {1'b0, duration_reg});

    assign idx_full = (quo_reg > QUO_W'(SINE_TABLE_ENTRIES)) ? QUO_W'(SINE_TABLE_ENTRIES)
                                                             : quo_reg;
    assign idx      = idx_full[IDX_W-1:0];
    assign rom_addr = up_reg ? idx : IDX_W'(SINE_TABLE_ENTRIES) - idx;

    always_comb begin
        if (cmd.apply_sel == APPLY_SINE) begin
            step_raw = prod_reg[PROD_W-1:VOLUME_FRACTION_BITS];
        end else begin
            step_raw = STEP_W'(quo_reg);
        end
        step_c = (step_raw > STEP_W'(d_reg)) ? d_reg : step_raw[VOL_W-1:0];
        if (cmd.apply_sel == APPLY_LIM) begin
            new_vol = lim_reg;
        end else if (up_reg) begin
            new_vol = start_reg + step_c;
        end else begin
            new_vol = start_reg - step_c;
        end
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= '0;
            duration_reg  <= '0;
            shape_cfg_reg <= SHAPE_LINEAR;
            stop_cfg_reg  <= 1'b0;
            current_reg   <= '0;
            start_reg     <= '0;
            elapsed_reg   <= '0;
            fade_reg      <= 1'b0;
            play_reg      <= 1'b0;
            stop_req_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            if (cfg_wr.wr_en) begin
                case (cfg_wr.index)
                    CFG_LIMIT:    limit_reg     <= cfg_wr.wdata;
                    CFG_DURATION: duration_reg  <= cfg_wr.wdata[ELAP_W-1:0];
                    CFG_SHAPE:    shape_cfg_reg <= cfg_wr.wdata[SHAPE_W-1:0];
                    CFG_STOP:     stop_cfg_reg  <= cfg_wr.wdata[0];
                    default: begin
                    end
                endcase
            end
            if (cmd.setup) begin
                stop_req_reg <= 1'b0;
                case (req_reg)
                    REQ_TICK: begin
                        if (elapsed_reg != TICK_MAX) begin
                            elapsed_reg <= elapsed_reg + 1'b1;
                        end
                    end
                    REQ_START: begin
                        if (play_reg) begin
                            start_reg   <= current_reg;
                            elapsed_reg <= '0;
                            fade_reg    <= 1'b1;
                        end
                    end
                    REQ_SET: begin
                        current_reg <= (nvol_reg > FULL_SCALE) ? FULL_SCALE : nvol_reg;
                        play_reg    <= nplay_reg;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.apply) begin
                current_reg <= new_vol;
                if (new_vol == lim_reg) begin
                    fade_reg <= 1'b0;
                end
                if ((new_vol == '0) && stop_cfg_reg) begin
                    stop_req_reg <= play_reg;
                    play_reg     <= 1'b0;
                    fade_reg     <= 1'b0;
                end
            end
            if (cmd.div_load) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg   <= in_req_type;
            nvol_reg  <= in_new_volume;
            nplay_reg <= in_new_playing;
        end
        if (cmd.setup) begin
            lim_reg <= lim_c;
            up_reg  <= up_c;
            d_reg   <= up_c ? lim_c - start_reg : start_reg - lim_c;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(d_reg) * PROD_W'(mul_b);
        end
        if (cmd.div_load) begin
            rem_reg <= div_num[DIV_NUM_W-1 -: ELAP_W];
            quo_reg <= div_num[QUO_W-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= div_bit ? ELAP_W'(div_trial - {1'b0, duration_reg})
                               : div_trial[ELAP_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], div_bit};
        end
        if (cmd.rom_rd) begin
            shape_reg <= up_reg ? sine_rom[rom_addr] : FULL_SCALE - sine_rom[rom_addr];
        end
        if (cmd.out_load) begin
            out_volume       <= current_reg;
            out_fading       <= fade_reg;
            out_playing      <= play_reg;
            out_stop_request <= stop_req_reg;
        end
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for volume_fade_envelope: a directed script, then random fade phases,
// checked against typed-in results or a fade predictor held inside this module.
// Depends on vfe_pkg and the volume_fade_envelope RTL only.
`timescale 1ns / 1ps

module tb_top;
    import vfe_pkg::*;

    // Bench pacing and limits.
    localparam int unsigned SINE_STEPS       = SINE_ENTRIES_DEFAULT;
    localparam int unsigned RESET_CYCLES     = 8;
    localparam int unsigned RANDOM_PHASES    = 8;
    localparam int unsigned PHASE_ITEMS      = 100;
    localparam int unsigned SINK_HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES     = 40;
    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned PRINT_LIMIT      = 100;

    // Request code 3 and shape code 3 are not named in the package.
    localparam logic [REQ_W-1:0]   REQ_UNUSED  = 2'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_SPARE = 2'd3;

    // One result transaction of the block.
    typedef struct packed {
        logic [VOL_W-1:0] volume;
        logic             fading;
        logic             playing;
        logic             stop_request;
    } fade_status_t;

    // One line of the directed script: either a register write or a request, the latter
    // optionally carrying a result that is typed in by hand.
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic [REQ_W-1:0]      req;
        logic [VOL_W-1:0]      new_volume;
        logic                  new_playing;
        logic                  known;
        fade_status_t          want;
    } script_row_t;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type     = '0;
    logic [VOL_W-1:0]      s_new_volume   = '0;
    logic                  s_new_playing  = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [VOL_W-1:0]      m_volume;
    logic                  m_fading;
    logic                  m_playing;
    logic                  m_stop_request;

    // Predictor copy of the registers (reset values of the block).
    logic [VOL_W-1:0]   fade_limit   = '0;
    logic [ELAP_W-1:0]  fade_length  = '0;
    logic [SHAPE_W-1:0] fade_curve   = SHAPE_LINEAR;
    logic               silence_stop = 1'b0;

    // Predictor copy of the channel state.
    logic [VOL_W-1:0]  vol_now       = '0;
    logic [VOL_W-1:0]  vol_start     = '0;
    logic [ELAP_W-1:0] ticks_elapsed = '0;
    logic              fade_on       = 1'b0;
    logic              play_on       = 1'b0;

    longint unsigned quarter_sine [0:SINE_STEPS];

    fade_status_t channel_status_due [$];
    int unsigned  sent_count        = 0;
    int unsigned  recv_count        = 0;
    int unsigned  mismatch_count    = 0;
    int unsigned  cycle_count       = 0;
    bit           steady_flow       = 1'b0;
    bit           sink_hold_request = 1'b0;

    volume_fade_envelope u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_new_volume   (s_new_volume),
        .s_new_playing  (s_new_playing),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_volume       (m_volume),
        .m_fading       (m_fading),
        .m_playing      (m_playing),
        .m_stop_request (m_stop_request)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs on either handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sine in Q30 by a 12-term Taylor series, every term truncated, as the table
    // of the block is defined.
    function automatic longint unsigned taylor_sine_q30(input longint unsigned x);
        longint unsigned x2, term, pos_sum, neg_sum;
        x2      = (x * x) >> 30;
        term    = x;
        pos_sum = x;
        neg_sum = 0;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) neg_sum += term;
            else pos_sum += term;
        end
        return (pos_sum > neg_sum) ? pos_sum - neg_sum : 0;
    endfunction

    // Volume that a fading tick produces from the captured start value.
    function automatic logic [VOL_W-1:0] faded_volume();
        longint unsigned lim, base, span, amount, frac_idx, curve;
        bit              rising;
        lim    = 64'((fade_limit > FULL_SCALE) ? FULL_SCALE : fade_limit);
        base   = 64'(vol_start);
        rising = lim > base;
        span   = rising ? lim - base : base - lim;
        if (fade_length == 0 || ticks_elapsed >= fade_length) return VOL_W'(lim);
        case (fade_curve)
            SHAPE_LINEAR: begin
                amount = (span * ticks_elapsed) / fade_length;
            end
            SHAPE_SINE: begin
                frac_idx = (longint'(ticks_elapsed) * SINE_STEPS) / fade_length;
                if (frac_idx > SINE_STEPS) frac_idx = SINE_STEPS;
                // Fade-in follows sin, fade-out follows 1 - cos (the mirrored table).
                curve = rising ? quarter_sine[frac_idx]
                               : FULL_SCALE - quarter_sine[SINE_STEPS - frac_idx];
                amount = (span * curve) >> VOLUME_FRACTION_BITS;
            end
            default: begin
                // Jump, and the spare shape code, go straight to the limit.
                return VOL_W'(lim);
            end
        endcase
        if (amount > span) amount = span;
        return VOL_W'(rising ? base + amount : base - amount);
    endfunction

    // Applies one accepted request to the predicted channel and returns its result.
    function automatic fade_status_t advance_channel(input logic [REQ_W-1:0] req,
                                                     input logic [VOL_W-1:0] nvol,
                                                     input logic nplay);
        fade_status_t     outcome;
        logic [VOL_W-1:0] lim, fresh;
        logic             stopped;
        stopped = 1'b0;
        lim     = (fade_limit > FULL_SCALE) ? FULL_SCALE : fade_limit;
        case (req)
            REQ_TICK: begin
                if (ticks_elapsed != TICK_MAX) ticks_elapsed = ticks_elapsed + 1'b1;
                if (fade_on) begin
                    fresh   = faded_volume();
                    vol_now = fresh;
                    if (fresh == lim) fade_on = 1'b0;
                    if (fresh == 0 && silence_stop) begin
                        // Only a channel that was still playing reports the stop.
                        stopped = play_on;
                        play_on = 1'b0;
                        fade_on = 1'b0;
                    end
                end
            end
            REQ_START: begin
                if (play_on) begin
                    vol_start     = vol_now;
                    ticks_elapsed = '0;
                    fade_on       = 1'b1;
                end
            end
            REQ_SET: begin
                vol_now = (nvol > FULL_SCALE) ? FULL_SCALE : nvol;
                play_on = nplay;
            end
            default: begin
            end
        endcase
        outcome.volume       = vol_now;
        outcome.fading       = fade_on;
        outcome.playing      = play_on;
        outcome.stop_request = stopped;
        return outcome;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offers one request and holds it until the block takes it. The expectation is
    // queued at the edge of the transaction.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [VOL_W-1:0] nvol,
                                input logic nplay, input logic known,
                                input fade_status_t want);
        fade_status_t predicted;
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_new_volume  <= nvol;
        s_new_playing <= nplay;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = advance_channel(req, nvol, nplay);
        channel_status_due = {channel_status_due, known ? want : predicted};
        sent_count++;
    endtask

    // Random source gaps, skipped during the steady stretch.
    task automatic pace_source();
        if (!steady_flow && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Stops offering and waits for every outstanding result.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (recv_count < sent_count) @(posedge aclk);
    endtask

    // One write cycle on the register port, followed by a quiet wait, so that back-to-back
    // writes never drive the enable twice in one step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            CFG_LIMIT:    fade_limit   = value;
            CFG_DURATION: fade_length  = value[ELAP_W-1:0];
            CFG_SHAPE:    fade_curve   = value[SHAPE_W-1:0];
            CFG_STOP:     silence_stop = value[0];
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] index,
                                            input logic [CFG_DATA_W-1:0] value);
        script_row_t row;
        row           = '0;
        row.is_write  = 1'b1;
        row.reg_index = index;
        row.reg_value = value;
        return row;
    endfunction

    function automatic script_row_t req_row(input logic [REQ_W-1:0] req,
                                            input logic [VOL_W-1:0] nvol,
                                            input logic nplay);
        script_row_t row;
        row             = '0;
        row.req         = req;
        row.new_volume  = nvol;
        row.new_playing = nplay;
        return row;
    endfunction

    function automatic script_row_t checked_row(input logic [REQ_W-1:0] req,
                                                input logic [VOL_W-1:0] nvol,
                                                input logic nplay,
                                                input logic [VOL_W-1:0] vol,
                                                input logic fading, input logic playing,
                                                input logic stop);
        script_row_t row;
        row       = req_row(req, nvol, nplay);
        row.known = 1'b1;
        row.want  = '{vol, fading, playing, stop};
        return row;
    endfunction

    // Volume stimulus weighted toward the saturation edges.
    function automatic logic [VOL_W-1:0] pick_volume();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FULL_SCALE;
            2:       return FULL_SCALE + 1'b1;
            3:       return '1;
            default: return VOL_W'($urandom_range(0, (1 << VOL_W) - 1));
        endcase
    endfunction

    // Random traffic for one register setting. Most of it is a well-formed fade:
    // set a playing volume, start the fade, then ticks (with the odd set mixed in).
    // The rest is single random requests, including the unused code.
    task automatic run_random_phase(input int unsigned items, input bit pause_midway);
        int unsigned counted, ticks, reach;
        bit          paused;
        logic [REQ_W-1:0] req;
        counted = 0;
        paused  = 1'b0;
        while (counted < items) begin
            if (pause_midway && !paused && counted >= items / 2) begin
                // The source holds back until the block has handed over everything.
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 70) begin
                send_request(REQ_SET, pick_volume(), 1'b1, 1'b0, '0);
                pace_source();
                send_request(REQ_START, pick_volume(), 1'($urandom_range(0, 1)), 1'b0, '0);
                pace_source();
                reach = (fade_length > 24) ? 24 : fade_length;
                ticks = $urandom_range(1, reach + 3);
                counted += 2 + ticks;
                repeat (ticks) begin
                    req = ($urandom_range(0, 99) < 8) ? REQ_SET : REQ_TICK;
                    send_request(req, pick_volume(), 1'($urandom_range(0, 1)), 1'b0, '0);
                    pace_source();
                end
            end else begin
                req = REQ_W'($urandom_range(0, 3));
                send_request(req, pick_volume(), 1'($urandom_range(0, 1)), 1'b0, '0);
                pace_source();
                if (req != REQ_UNUSED) counted++;
            end
        end
    endtask

    // Result side: random back-pressure, a steady stretch, and one long hold-off
    // that the stimulus asks for and this process times on its own.
    initial begin : sink_pacing
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (sink_hold_request) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold_request = 1'b0;
            end else if (steady_flow) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Every result transaction is compared with the oldest expectation, field by field.
    always @(posedge aclk) begin
        fade_status_t want;
        if (aresetn && m_valid && m_ready) begin
            recv_count++;
            if (channel_status_due.size() == 0) begin
                report_mismatch("result with nothing expected, volume", 64'(m_volume), 0);
            end else begin
                want = channel_status_due.pop_front();
                if (m_volume !== want.volume)
                    report_mismatch("volume", 64'(m_volume), 64'(want.volume));
                if (m_fading !== want.fading)
                    report_mismatch("fading", 64'(m_fading), 64'(want.fading));
                if (m_playing !== want.playing)
                    report_mismatch("playing", 64'(m_playing), 64'(want.playing));
                if (m_stop_request !== want.stop_request)
                    report_mismatch("stop_request", 64'(m_stop_request),
                                    64'(want.stop_request));
            end
        end
    end

    initial begin : stimulus
        script_row_t        script [$];
        longint unsigned    sine_val, rounded;
        logic [VOL_W-1:0]   lim_pick;
        logic [ELAP_W-1:0]  dur_pick;
        logic [SHAPE_W-1:0] shape_pick;
        logic               stop_pick;

        // Quarter-sine table, rounded half up to the volume format and capped at 1.0.
        for (int i = 0; i <= SINE_STEPS; i++) begin
            sine_val = taylor_sine_q30((longint'(i) * HALF_PI_Q30) / SINE_STEPS);
            rounded  = (sine_val + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            quarter_sine[i] = (rounded > FULL_SCALE) ? FULL_SCALE : rounded;
        end

        // Directed script, starting from reset values: zero limit, zero length, linear.
        // Idle channel: a tick, a start while stopped and the unused code change nothing.
        script = {script, checked_row(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0)};
        script = {script, checked_row(REQ_START, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0)};
        script = {script, checked_row(REQ_UNUSED, '1, 1'b1, '0, 1'b0, 1'b0, 1'b0)};
        // Largest volume saturates to full scale; a zero-length fade lands at once.
        script = {script, checked_row(REQ_SET, '1, 1'b1, FULL_SCALE, 1'b0, 1'b1, 1'b0)};
        script = {script, checked_row(REQ_START, '0, 1'b0, FULL_SCALE, 1'b1, 1'b1, 1'b0)};
        script = {script, checked_row(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b1, 1'b0)};
        // Same again with stop at silence: playback stops and the stop is flagged.
        script = {script, reg_row(CFG_STOP, 17'd1)};
        script = {script, checked_row(REQ_SET, FULL_SCALE, 1'b1, FULL_SCALE, 1'b0, 1'b1, 1'b0)};
        script = {script, checked_row(REQ_START, '0, 1'b0, FULL_SCALE, 1'b1, 1'b1, 1'b0)};
        script = {script, checked_row(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1)};
        // Linear fade-in over four ticks, limit above full scale, a set in the middle.
        script = {script, reg_row(CFG_LIMIT, '1)};
        script = {script, reg_row(CFG_DURATION, 17'd4)};
        script = {script, checked_row(REQ_SET, '0, 1'b1, '0, 1'b0, 1'b1, 1'b0)};
        script = {script, checked_row(REQ_START, '0, 1'b0, '0, 1'b1, 1'b1, 1'b0)};
        script = {script, req_row(REQ_TICK, '0, 1'b0)};
        script = {script, checked_row(REQ_SET, 17'd40000, 1'b1, 17'd40000, 1'b1, 1'b1, 1'b0)};
        script = {script, req_row(REQ_TICK, '0, 1'b0)};
        script = {script, req_row(REQ_TICK, '0, 1'b0)};
        script = {script, checked_row(REQ_TICK, '0, 1'b0, FULL_SCALE, 1'b0, 1'b1, 1'b0)};
        // Quarter-sine fade-out; the channel is stopped mid-fade, so reaching silence
        // ends the fade without a stop flag.
        script = {script, reg_row(CFG_SHAPE, CFG_DATA_W'(SHAPE_SINE))};
        script = {script, reg_row(CFG_LIMIT, '0)};
        script = {script, reg_row(CFG_DURATION, 17'd5)};
        script = {script, checked_row(REQ_START, '0, 1'b0, FULL_SCALE, 1'b1, 1'b1, 1'b0)};
        script = {script, req_row(REQ_TICK, '0, 1'b0)};
        script = {script, checked_row(REQ_SET, 17'd20000, 1'b0, 17'd20000, 1'b1, 1'b0, 1'b0)};
        script = {script, req_row(REQ_TICK, '0, 1'b0)};
        script = {script, reg_row(CFG_DURATION, '0)};
        script = {script, checked_row(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0)};
        // Spare shape code and the jump shape both go straight to the limit, even with
        // the longest length.
        script = {script, reg_row(CFG_STOP, '0)};
        script = {script, reg_row(CFG_SHAPE, CFG_DATA_W'(SHAPE_SPARE))};
        script = {script, reg_row(CFG_LIMIT, 17'd30000)};
        script = {script, reg_row(CFG_DURATION, 17'd32767)};
        script = {script, checked_row(REQ_SET, 17'd100, 1'b1, 17'd100, 1'b0, 1'b1, 1'b0)};
        script = {script, checked_row(REQ_START, '0, 1'b0, 17'd100, 1'b1, 1'b1, 1'b0)};
        script = {script, checked_row(REQ_TICK, '0, 1'b0, 17'd30000, 1'b0, 1'b1, 1'b0)};
        script = {script, reg_row(CFG_SHAPE, CFG_DATA_W'(SHAPE_JUMP))};
        script = {script, reg_row(CFG_LIMIT, 17'd7)};
        script = {script, checked_row(REQ_START, '0, 1'b0, 17'd30000, 1'b1, 1'b1, 1'b0)};
        script = {script, checked_row(REQ_TICK, '0, 1'b0, 17'd7, 1'b0, 1'b1, 1'b0)};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers change only with the block idle, i.e. with every result handed over.
        foreach (script[i]) begin
            if (script[i].is_write) begin
                wait_drained();
                write_register(script[i].reg_index, script[i].reg_value);
            end else begin
                send_request(script[i].req, script[i].new_volume, script[i].new_playing,
                             script[i].known, script[i].want);
                pace_source();
            end
        end

        // Random phases. The first three pin the register extremes; the rest draw
        // settings at random, with short lengths favored so that fades finish.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    lim_pick = '1; dur_pick = '1; shape_pick = SHAPE_SINE; stop_pick = 1'b1;
                end
                1: begin
                    lim_pick = '0; dur_pick = '0; shape_pick = SHAPE_JUMP; stop_pick = 1'b0;
                end
                2: begin
                    lim_pick = FULL_SCALE; dur_pick = 15'd1; shape_pick = SHAPE_LINEAR;
                    stop_pick = 1'b1;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0:       lim_pick = '0;
                        1:       lim_pick = FULL_SCALE;
                        2:       lim_pick = '1;
                        3:       lim_pick = VOL_W'($urandom_range(0, FULL_SCALE));
                        default: lim_pick = VOL_W'($urandom_range(0, (1 << VOL_W) - 1));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       dur_pick = '0;
                        1:       dur_pick = '1;
                        2:       dur_pick = ELAP_W'($urandom_range(0, (1 << ELAP_W) - 1));
                        default: dur_pick = ELAP_W'($urandom_range(1, 16));
                    endcase
                    shape_pick = SHAPE_W'($urandom_range(0, 3));
                    stop_pick  = 1'($urandom_range(0, 1));
                end
            endcase
            write_register(CFG_LIMIT, lim_pick);
            write_register(CFG_DURATION, CFG_DATA_W'(dur_pick));
            write_register(CFG_SHAPE, CFG_DATA_W'(shape_pick));
            write_register(CFG_STOP, CFG_DATA_W'(stop_pick));

            // Phase 3 runs with no idling on either side; phase 4 opens with a long
            // hold-off on the result side while requests keep coming, so the block
            // backs up into its input; phase 6 pauses the source halfway.
            steady_flow = (phase == 3);
            if (phase == 4) sink_hold_request = 1'b1;
            run_random_phase(PHASE_ITEMS, phase == 6);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (channel_status_due.size() != 0)
            report_mismatch("results never delivered, count",
                            64'(channel_status_due.size()), 0);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/vfe_pkg.sv
rtl/core/vfe_ctrl.sv
rtl/core/vfe_datapath.sv
rtl/core/volume_fade_envelope.sv
bench/tb_top.sv
